// File: rtl/mppt_incremental_conductance_macros.svh
// Assertion macros for the incremental-conductance tracker.
// Used by the top level; depends on nothing.
`ifndef MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH
`define MPPT_INCREMENTAL_CONDUCTANCE_MACROS_SVH

// same-cycle implication
`define MPPT_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MPPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mppt_ic_pkg.sv
// Shared widths, constants, codes and controller/datapath interface types
// for the incremental-conductance tracker. Depends on nothing.
package mppt_ic_pkg;

   localparam int PWM_PERIOD = 64;

   localparam int V_W     = 14;
   localparam int I_W     = 13;
   localparam int DUTY_W  = 7;
   localparam int DU_W    = V_W + 1;
   localparam int DI_W    = I_W + 1;
   localparam int PROD_W  = 24;
   localparam int MAG_W   = PROD_W - 1;
   localparam int DEN_W   = V_W;
   localparam int CNT_W   = $clog2(MAG_W + 1);
   localparam int SCALE_W = 11;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = V_W;

   localparam logic signed [SCALE_W-1:0] SCALE = SCALE_W'(1000);
   localparam logic [DUTY_W-1:0] DUTY_RESET     = DUTY_W'(5);
   localparam logic [DUTY_W-1:0] DUTY_TOP       = '1;
   localparam logic [DUTY_W-1:0] MAX_DUTY_RESET = DUTY_W'(PWM_PERIOD - PWM_PERIOD / 10);
   localparam logic [V_W-1:0]    CUTOFF_RESET   = V_W'(4200);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_DUTY = 1'b0,
      REG_CUTOFF   = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      MODE_HOLD,
      MODE_CURRENT,
      MODE_SLOPE
   } step_mode_type;

   typedef struct packed {
      logic          load;
      logic          diff;
      logic          mul;
      logic          sel;
      logic          div_start;
      logic          save_q1;
      logic          update;
      step_mode_type mode;
   } ctrl_cmd_type;

   typedef struct packed {
      logic du_zero;
      logic u_zero;
      logic div_done;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

// File: rtl/mppt_ic_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, signed result.
// Depends on mppt_ic_pkg.
module mppt_ic_div import mppt_ic_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [MAG_W-1:0]         num_mag,
   input  logic [DEN_W-1:0]         den_mag,
   input  logic                     neg,
   output logic                     busy,
   output logic                     done,
   output logic signed [PROD_W-1:0] quotient
);

   logic [MAG_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;
   logic             qbit;

   always_comb begin
      trial  = {rem_ff, num_ff[MAG_W-1]};
      qbit   = (trial >= {1'b0, den_ff});
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num_mag;
         rem_in  = '0;
         den_in  = den_mag;
         neg_in  = neg;
         cnt_in  = CNT_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         num_in = {num_ff[MAG_W-2:0], qbit};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});

endmodule

// File: rtl/mppt_ic_dp.sv
// Tracker datapath: samples, differences, scaling multiply, shared divider,
// duty update, configuration registers and result register.
// Depends on mppt_ic_pkg and mppt_ic_div.
module mppt_ic_dp import mppt_ic_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  ctrl_cmd_type         cmd,
   output dp_status_type        status,
   input  logic [V_W-1:0]       req_solar_voltage_mv,
   input  logic signed [I_W-1:0] req_solar_current_ma,
   input  logic [V_W-1:0]       req_battery_voltage_mv,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DUTY_W-1:0]    rsp_applied_duty,
   output logic [DUTY_W-1:0]    rsp_tracked_duty,
   output logic                 rsp_cutoff_active
);

   logic [V_W-1:0]           u_ff, vbat_ff, prev_v_ff;
   logic signed [I_W-1:0]    i_ff, prev_i_ff;
   logic signed [DU_W-1:0]   du_ff;
   logic signed [DI_W-1:0]   di_ff;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] q1_ff;
   logic signed [PROD_W-1:0] q2;
   logic [DUTY_W-1:0]        duty_ff, duty_step, duty_clamp;
   logic [DUTY_W-1:0]        max_duty_ff;
   logic [V_W-1:0]           cutoff_ff;
   logic                     rsp_valid_ff;
   logic [DUTY_W-1:0]        applied_ff, tracked_ff;
   logic                     cut_ff;
   logic signed [DI_W-1:0]   mul_a;
   logic [MAG_W-1:0]         num_mag;
   logic [DEN_W-1:0]         den_mag;
   logic [DU_W-1:0]          du_abs;
   logic                     div_neg, div_busy, div_done;
   logic                     go_down, go_up, cut;
   reg_index_type            idx;

   always_comb begin
      mul_a   = cmd.sel ? -$signed({i_ff[I_W-1], i_ff}) : di_ff;
      prod_in = PROD_W'(mul_a) * PROD_W'(SCALE);
      du_abs  = du_ff[DU_W-1] ? DU_W'(-du_ff) : DU_W'(du_ff);
      num_mag = prod_ff[PROD_W-1] ? MAG_W'(-prod_ff) : prod_ff[MAG_W-1:0];
      den_mag = cmd.sel ? u_ff : du_abs[DEN_W-1:0];
      div_neg = prod_ff[PROD_W-1] ^ (cmd.sel ? 1'b0 : du_ff[DU_W-1]);
   end

   mppt_ic_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num_mag  (num_mag),
      .den_mag  (den_mag),
      .neg      (div_neg),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (q2)
   );

   always_comb begin
      go_down = 1'b0;
      go_up   = 1'b0;
      case (cmd.mode)
         MODE_CURRENT: begin
            go_down = (di_ff > 0);
            go_up   = (di_ff < 0);
         end
         MODE_SLOPE: begin
            go_down = (q1_ff > q2);
            go_up   = (q1_ff < q2);
         end
         default: begin
            go_down = 1'b0;
            go_up   = 1'b0;
         end
      endcase
      duty_step = duty_ff;
      if (go_down && duty_ff != '0) duty_step = duty_ff - DUTY_W'(1);
      if (go_up && duty_ff != DUTY_TOP) duty_step = duty_ff + DUTY_W'(1);
      duty_clamp = (duty_step > max_duty_ff) ? max_duty_ff : duty_step;
      cut = (vbat_ff >= cutoff_ff);
      idx = reg_index_type'(csr_index);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         u_ff    <= req_solar_voltage_mv;
         i_ff    <= req_solar_current_ma;
         vbat_ff <= req_battery_voltage_mv;
      end
      if (cmd.diff) begin
         du_ff <= $signed({1'b0, u_ff}) - $signed({1'b0, prev_v_ff});
         di_ff <= DI_W'(i_ff) - DI_W'(prev_i_ff);
      end
      if (cmd.mul) prod_ff <= prod_in;
      if (cmd.save_q1) q1_ff <= q2;
      if (cmd.update) begin
         tracked_ff <= duty_clamp;
         applied_ff <= cut ? '0 : duty_clamp;
         cut_ff     <= cut;
      end
      if (reset) begin
         prev_v_ff    <= '0;
         prev_i_ff    <= '0;
         duty_ff      <= DUTY_RESET;
         max_duty_ff  <= MAX_DUTY_RESET;
         cutoff_ff    <= CUTOFF_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) begin
            duty_ff   <= duty_clamp;
            prev_v_ff <= u_ff;
            prev_i_ff <= i_ff;
         end
         if (csr_wr_en) begin
            case (idx)
               REG_MAX_DUTY: max_duty_ff <= csr_wr_data[DUTY_W-1:0];
               REG_CUTOFF:   cutoff_ff   <= csr_wr_data[V_W-1:0];
               default:      cutoff_ff   <= cutoff_ff;
            endcase
         end
         if (cmd.update) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_comb begin
      status.du_zero  = (du_ff == '0);
      status.u_zero   = (u_ff == '0);
      status.div_done = div_done;
      status.div_busy = div_busy;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_applied_duty  = applied_ff;
   assign rsp_tracked_duty  = tracked_ff;
   assign rsp_cutoff_active = cut_ff;

endmodule

// File: rtl/mppt_ic_ctrl.sv
// Tracker controller: sample, difference, two divisions if needed, update.
// Depends on mppt_ic_pkg.
module mppt_ic_ctrl import mppt_ic_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,
      S_DECIDE,
      S_MUL1,
      S_LOAD1,
      S_DIV1,
      S_MUL2,
      S_LOAD2,
      S_DIV2,
      S_UPDATE
   } state_type;

   state_type     state_ff, state_in;
   step_mode_type mode_ff, mode_in;
   logic          req_ready_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.mode = mode_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.load = 1'b1;
               state_in = S_DIFF;
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (status.du_zero) begin
               mode_in  = MODE_CURRENT;
               state_in = S_UPDATE;
            end else if (status.u_zero) begin
               mode_in  = MODE_HOLD;
               state_in = S_UPDATE;
            end else begin
               mode_in  = MODE_SLOPE;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul  = 1'b1;
            state_in = S_LOAD1;
         end
         S_LOAD1: begin
            cmd.div_start = 1'b1;
            state_in      = S_DIV1;
         end
         S_DIV1: begin
            if (status.div_done) begin
               cmd.save_q1 = 1'b1;
               state_in    = S_MUL2;
            end
         end
         S_MUL2: begin
            cmd.mul  = 1'b1;
            cmd.sel  = 1'b1;
            state_in = S_LOAD2;
         end
         S_LOAD2: begin
            cmd.sel       = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = S_DIV2;
         end
         S_DIV2: begin
            if (status.div_done) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (status.out_free) begin
               cmd.update = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= MODE_HOLD;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         req_ready_ff <= (state_in == S_IDLE);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// File: rtl/mppt_incremental_conductance.sv
// Incremental-conductance tracker top level: one result per item.
// With no voltage change or zero voltage the divisions are skipped; otherwise
// the two 23-step divisions run in turn through the one shared divider.
// One item in flight; the next is taken while a result waits in the output register.
// Synchronous active-high reset: duty 5, previous samples 0, registers to defaults.
`include "mppt_incremental_conductance_macros.svh"
module mppt_incremental_conductance import mppt_ic_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [V_W-1:0]        req_solar_voltage_mv,
   input  logic signed [I_W-1:0] req_solar_current_ma,
   input  logic [V_W-1:0]        req_battery_voltage_mv,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [DUTY_W-1:0]     rsp_applied_duty,
   output logic [DUTY_W-1:0]     rsp_tracked_duty,
   output logic                  rsp_cutoff_active,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mppt_ic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mppt_ic_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .req_solar_voltage_mv   (req_solar_voltage_mv),
      .req_solar_current_ma   (req_solar_current_ma),
      .req_battery_voltage_mv (req_battery_voltage_mv),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_wr_data            (csr_wr_data),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_applied_duty       (rsp_applied_duty),
      .rsp_tracked_duty       (rsp_tracked_duty),
      .rsp_cutoff_active      (rsp_cutoff_active)
   );

   `MPPT_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "second item taken while busy")
   `MPPT_ASSERT_IMPL(a_div_busy, clock, reset, status.div_busy, !req_ready, "divider busy while ready")
   `MPPT_ASSERT_IMPL(a_cutoff_zero, clock, reset, rsp_valid && rsp_cutoff_active, rsp_applied_duty == '0, "duty applied in cutoff")
   `MPPT_ASSERT_IMPL(a_duty_match, clock, reset, rsp_valid && !rsp_cutoff_active, rsp_applied_duty == rsp_tracked_duty, "applied differs from tracked")

endmodule
